// ===== rtl/wmps_pkg.sv =====
// Shared types and constants for the radio module power sequencer.
// No dependencies; imported by both RTL files, the checker and the bench.
`timescale 1ns / 1ps

package wmps_pkg;

  // Input command codes
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_RXBYTE = 3'd1;
  localparam logic [2:0] CMD_SLEEP  = 3'd2;
  localparam logic [2:0] CMD_WAKE   = 3'd3;
  localparam logic [2:0] CMD_RELOAD = 3'd4;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_WAIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_PULSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE_PULSE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_PULSE = 3'd5;

  // Register reset values (ticks of 100 ms)
  localparam logic [15:0] HEARTBEAT_RST    = 16'd3000;
  localparam logic [3:0]  RETRY_LIMIT_RST  = 4'd3;
  localparam logic [15:0] BOOT_WAIT_RST    = 16'd150;
  localparam logic [15:0] SLEEP_PULSE_RST  = 16'd30;
  localparam logic [15:0] WAKE_PULSE_RST   = 16'd10;
  localparam logic [15:0] RELOAD_PULSE_RST = 16'd50;

  // Fixed waits
  localparam logic [15:0] RESET_HOLD_TICKS  = 16'd1;
  localparam logic [15:0] SLEEP_CHECK_TICKS = 16'd1;
  localparam logic [15:0] WAKE_CHECK_TICKS  = 16'd100;
  localparam logic [15:0] WAKE_READY_TICKS  = 16'd50;
  localparam logic [15:0] RELOAD_GAP_TICKS  = 16'd2;

  // Sequencer states, numbered as reported in state_code
  typedef enum logic [3:0] {
    ST_RST        = 4'd0,
    ST_RST_HOLD   = 4'd1,
    ST_WAIT_RDY   = 4'd2,
    ST_READY      = 4'd3,
    ST_ENTER_SLP  = 4'd4,
    ST_SLP_PULSE  = 4'd5,
    ST_SLP_CHK    = 4'd6,
    ST_ASLEEP     = 4'd7,
    ST_WAKE       = 4'd8,
    ST_WAKE_PULSE = 4'd9,
    ST_WAKE_CHK   = 4'd10,
    ST_RELOAD     = 4'd11,
    ST_RELOAD_PUL = 4'd12,
    ST_ERROR      = 4'd13
  } seq_state_t;

  // Live timing registers used by the state update
  typedef struct packed {
    logic [15:0] heartbeat_ticks;
    logic [15:0] boot_wait_ticks;
    logic [15:0] sleep_pulse_ticks;
    logic [15:0] wake_pulse_ticks;
    logic [15:0] reload_pulse_ticks;
  } cfg_t;

  // Sequencer state carried from item to item
  typedef struct packed {
    seq_state_t  state;
    logic [15:0] delay_count;
    logic [15:0] heartbeat_count;
    logic [3:0]  tries_left;
    logic        reset_pin;
    logic        sleep_req_pin;
    logic        reload_pin;
  } seq_regs_t;

endpackage

// ===== rtl/wmps_step.sv =====
// Next-state logic of the power sequencer for one command beat.
// Depends on wmps_pkg for the state, register and command types.
`timescale 1ns / 1ps

module wmps_step (
  input  logic [2:0]         cmd,
  input  logic               ready_n,
  input  logic               sleep_status,
  input  wmps_pkg::cfg_t     cfg,
  input  wmps_pkg::seq_regs_t cur,
  output wmps_pkg::seq_regs_t nxt,
  output logic               err
);
  import wmps_pkg::*;

  logic [15:0] dly_dec;
  logic [15:0] hb_dec;

  // Saturating countdown applied on every tick before the state acts
  assign dly_dec = (cur.delay_count != 16'd0) ? cur.delay_count - 16'd1 : 16'd0;
  assign hb_dec  = (cur.heartbeat_count != 16'd0) ? cur.heartbeat_count - 16'd1 : 16'd0;

  always_comb begin
    nxt = cur;
    err = 1'b0;
    unique case (cmd)
      CMD_TICK: begin
        nxt.delay_count     = dly_dec;
        nxt.heartbeat_count = hb_dec;
        unique case (cur.state)
          ST_RST: begin
            nxt.reset_pin   = 1'b0;
            nxt.delay_count = RESET_HOLD_TICKS;
            nxt.state       = ST_RST_HOLD;
          end
          ST_RST_HOLD: begin
            if (dly_dec == 16'd0) begin
              nxt.reset_pin   = 1'b1;
              nxt.delay_count = cfg.boot_wait_ticks;
              nxt.state       = ST_WAIT_RDY;
            end
          end
          ST_WAIT_RDY: begin
            if (!ready_n) begin
              nxt.delay_count = cfg.heartbeat_ticks;
              nxt.state       = ST_READY;
            end else if (dly_dec == 16'd0) begin
              if (cur.tries_left != 4'd0) begin
                nxt.tries_left = cur.tries_left - 4'd1;
                nxt.state      = ST_RST;
              end else begin
                nxt.state = ST_ERROR;
                err       = 1'b1;
              end
            end
          end
          ST_READY: begin
            // heartbeat expired: reload and reboot the module
            if (hb_dec == 16'd0) begin
              nxt.heartbeat_count = cfg.heartbeat_ticks;
              nxt.state           = ST_RST;
            end
          end
          ST_ENTER_SLP: begin
            if (!sleep_status) begin
              nxt.state = ST_ASLEEP;
            end else begin
              nxt.sleep_req_pin = 1'b0;
              nxt.delay_count   = cfg.sleep_pulse_ticks;
              nxt.state         = ST_SLP_PULSE;
            end
          end
          ST_SLP_PULSE: begin
            if (dly_dec == 16'd0) begin
              nxt.sleep_req_pin = 1'b1;
              nxt.delay_count   = SLEEP_CHECK_TICKS;
              nxt.state         = ST_SLP_CHK;
            end
          end
          ST_SLP_CHK: begin
            if (!sleep_status) begin
              nxt.state = ST_ASLEEP;
            end else if (dly_dec == 16'd0) begin
              nxt.state = ST_ERROR;
              err       = 1'b1;
            end
          end
          ST_WAKE: begin
            if (sleep_status) begin
              nxt.state = ST_READY;
            end else begin
              nxt.sleep_req_pin = 1'b0;
              nxt.delay_count   = cfg.wake_pulse_ticks;
              nxt.state         = ST_WAKE_PULSE;
            end
          end
          ST_WAKE_PULSE: begin
            if (dly_dec == 16'd0) begin
              nxt.sleep_req_pin = 1'b1;
              nxt.delay_count   = WAKE_CHECK_TICKS;
              nxt.state         = ST_WAKE_CHK;
            end
          end
          ST_WAKE_CHK: begin
            if (sleep_status) begin
              nxt.delay_count = WAKE_READY_TICKS;
              nxt.state       = ST_WAIT_RDY;
            end else if (dly_dec == 16'd0) begin
              nxt.state = ST_ERROR;
              err       = 1'b1;
            end
          end
          ST_RELOAD: begin
            nxt.reload_pin  = 1'b0;
            nxt.delay_count = cfg.reload_pulse_ticks;
            nxt.state       = ST_RELOAD_PUL;
          end
          ST_RELOAD_PUL: begin
            if (dly_dec == 16'd0) begin
              nxt.reload_pin  = 1'b1;
              nxt.delay_count = RELOAD_GAP_TICKS;
              nxt.state       = ST_RST;
            end
          end
          ST_ERROR: begin
            nxt.state = ST_RST;
          end
          default: begin
            // asleep, or an unused code: nothing moves but the counters
          end
        endcase
      end
      CMD_RXBYTE: nxt.heartbeat_count = cfg.heartbeat_ticks;
      CMD_SLEEP:  nxt.state = ST_ENTER_SLP;
      CMD_WAKE:   nxt.state = ST_WAKE;
      CMD_RELOAD: nxt.state = ST_RELOAD;
      default: begin
        // unused command codes leave everything as it is
      end
    endcase
  end

endmodule

// ===== rtl/wifi_module_power_sequencer.sv =====
// Top level of the radio module power sequencer: config registers, state
// registers and the result register. Depends on wmps_pkg and wmps_step.
`timescale 1ns / 1ps

// One input beat (tick, received byte, or a sleep/wake/reload request)
// produces exactly one result beat carrying the pin levels and sequencer
// state after that beat. The state update is combinational logic from the
// state registers to the result register, so a beat is accepted every cycle
// and its result appears on the next cycle; in_tready only drops while a
// result is held by out_tready low. Configuration writes are always taken
// (cfg_ready is tied high); the retry counter is loaded only at reset, from
// the fixed reset value, so writes to retry_limit never take effect.
module wifi_module_power_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // input beats; tuser: cmd[2:0]
  // tdata: ready_n[0], sleep_status[1], zero pad [7:2]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,
  input  logic [7:0]  in_tdata,
  // results; tdata: reset_line[0], sleep_request_line[1], reload_line[2],
  // state_code[6:3], link_ready[7], error_seen[8], zero pad [15:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wmps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import wmps_pkg::*;

  cfg_t      cfg_r;
  seq_regs_t seq_r;
  seq_regs_t seq_nxt;
  logic      err_nxt;
  logic      in_acc;
  logic      out_vld_r;
  logic [15:0] out_data_r;
  logic [15:0] out_data_nxt;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_vld_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heartbeat_ticks    <= HEARTBEAT_RST;
      cfg_r.boot_wait_ticks    <= BOOT_WAIT_RST;
      cfg_r.sleep_pulse_ticks  <= SLEEP_PULSE_RST;
      cfg_r.wake_pulse_ticks   <= WAKE_PULSE_RST;
      cfg_r.reload_pulse_ticks <= RELOAD_PULSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HEARTBEAT:    cfg_r.heartbeat_ticks    <= cfg_data;
        REG_RETRY_LIMIT:  ; // only the reset value is ever used
        REG_BOOT_WAIT:    cfg_r.boot_wait_ticks    <= cfg_data;
        REG_SLEEP_PULSE:  cfg_r.sleep_pulse_ticks  <= cfg_data;
        REG_WAKE_PULSE:   cfg_r.wake_pulse_ticks   <= cfg_data;
        REG_RELOAD_PULSE: cfg_r.reload_pulse_ticks <= cfg_data;
        default:          ;
      endcase
    end
  end

  // State update for the accepted beat
  wmps_step u_step (
    .cmd          (in_tuser),
    .ready_n      (in_tdata[0]),
    .sleep_status (in_tdata[1]),
    .cfg          (cfg_r),
    .cur          (seq_r),
    .nxt          (seq_nxt),
    .err          (err_nxt)
  );

  // Result packing
  assign out_data_nxt = {7'd0, err_nxt, (seq_nxt.state == ST_READY),
                         seq_nxt.state, seq_nxt.reload_pin,
                         seq_nxt.sleep_req_pin, seq_nxt.reset_pin};

  // Sequencer state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r.state           <= ST_RST;
      seq_r.delay_count     <= 16'd0;
      seq_r.heartbeat_count <= HEARTBEAT_RST;
      seq_r.tries_left      <= RETRY_LIMIT_RST;
      seq_r.reset_pin       <= 1'b1;
      seq_r.sleep_req_pin   <= 1'b1;
      seq_r.reload_pin      <= 1'b1;
      out_vld_r             <= 1'b0;
    end else begin
      if (in_acc) begin
        seq_r     <= seq_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_link_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_data_r[7] == (out_data_r[6:3] == ST_READY)))
    else $error("link_ready disagrees with state_code");

  a_err_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r[8]) |-> (out_data_r[6:3] == ST_ERROR))
    else $error("error_seen without error state");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !in_tready)
    else $error("beat accepted while result is stalled");

  a_tries: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (seq_r.tries_left <= $past(seq_r.tries_left)))
    else $error("retry counter increased");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(in_acc) && $past(rst_n)) |-> $stable(seq_r))
    else $error("sequencer state moved without a beat");

endmodule

// ===== verif/wmps_checker.sv =====
// Scoreboard for the radio module power sequencer: watches the input, result
// and configuration channels, predicts each result beat and compares it.
// Depends on wmps_pkg for command codes, register indexes, states and waits.
`timescale 1ns / 1ps

module wmps_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [2:0]  in_tuser,   // cmd[2:0]
  input  logic [7:0]  in_tdata,   // ready_n[0], sleep_status[1], pad
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // reset, sleep req, reload, state[6:3], link, err
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [wmps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned pending_results
);
  import wmps_pkg::*;

  // Result fields, lowest bit last so the struct lines up with out_tdata[8:0]
  typedef struct packed {
    logic       error_seen;
    logic       link_ready;
    logic [3:0] state_code;
    logic       reload_line;
    logic       sleep_request_line;
    logic       reset_line;
  } seq_pins_t;

  seq_pins_t expected_pins_q[$];

  // Shadow copy of the timing registers
  logic [15:0] hb_ticks, boot_wait, slp_pulse, wake_pulse, rel_pulse;
  logic [3:0]  retry_lim;

  // Shadow copy of the sequencer state
  seq_state_t  st;
  logic [15:0] dly, hb;
  logic [3:0]  tries;
  logic        pin_rst, pin_slp, pin_rel;

  function void check_field(input string name, input logic [3:0] want,
                            input logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Apply one input beat to the shadow state and return the pin levels after it
  task step_sequencer(input logic [2:0] cmd, input logic rdy_n, input logic slp_on,
                      output seq_pins_t res);
    logic err;
    err = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (dly != 16'd0) dly = dly - 16'd1;
        if (hb != 16'd0) hb = hb - 16'd1;
        case (st)
          ST_RST: begin
            pin_rst = 1'b0;
            dly     = RESET_HOLD_TICKS;
            st      = ST_RST_HOLD;
          end
          ST_RST_HOLD: if (dly == 16'd0) begin
            pin_rst = 1'b1;
            dly     = boot_wait;
            st      = ST_WAIT_RDY;
          end
          ST_WAIT_RDY: begin
            if (!rdy_n) begin
              // delay reloads from the heartbeat register here, as the block does
              dly = hb_ticks;
              st  = ST_READY;
            end else if (dly == 16'd0) begin
              if (tries != 4'd0) begin
                tries = tries - 4'd1;
                st    = ST_RST;
              end else begin
                st  = ST_ERROR;
                err = 1'b1;
              end
            end
          end
          ST_READY: if (hb == 16'd0) begin
            hb = hb_ticks;
            st = ST_RST;
          end
          ST_ENTER_SLP: begin
            if (!slp_on) begin
              st = ST_ASLEEP;
            end else begin
              pin_slp = 1'b0;
              dly     = slp_pulse;
              st      = ST_SLP_PULSE;
            end
          end
          ST_SLP_PULSE: if (dly == 16'd0) begin
            pin_slp = 1'b1;
            dly     = SLEEP_CHECK_TICKS;
            st      = ST_SLP_CHK;
          end
          ST_SLP_CHK: begin
            if (!slp_on) begin
              st = ST_ASLEEP;
            end else if (dly == 16'd0) begin
              st  = ST_ERROR;
              err = 1'b1;
            end
          end
          ST_WAKE: begin
            if (slp_on) begin
              st = ST_READY;
            end else begin
              pin_slp = 1'b0;
              dly     = wake_pulse;
              st      = ST_WAKE_PULSE;
            end
          end
          ST_WAKE_PULSE: if (dly == 16'd0) begin
            pin_slp = 1'b1;
            dly     = WAKE_CHECK_TICKS;
            st      = ST_WAKE_CHK;
          end
          ST_WAKE_CHK: begin
            if (slp_on) begin
              dly = WAKE_READY_TICKS;
              st  = ST_WAIT_RDY;
            end else if (dly == 16'd0) begin
              st  = ST_ERROR;
              err = 1'b1;
            end
          end
          ST_RELOAD: begin
            pin_rel = 1'b0;
            dly     = rel_pulse;
            st      = ST_RELOAD_PUL;
          end
          ST_RELOAD_PUL: if (dly == 16'd0) begin
            pin_rel = 1'b1;
            dly     = RELOAD_GAP_TICKS;
            st      = ST_RST;
          end
          ST_ERROR: st = ST_RST;
          default: ;
        endcase
      end
      CMD_RXBYTE: hb = hb_ticks;
      CMD_SLEEP:  st = ST_ENTER_SLP;
      CMD_WAKE:   st = ST_WAKE;
      CMD_RELOAD: st = ST_RELOAD;
      default: ;  // unused codes leave everything alone
    endcase
    res.reset_line         = pin_rst;
    res.sleep_request_line = pin_slp;
    res.reload_line        = pin_rel;
    res.state_code         = st;
    res.link_ready         = (st == ST_READY);
    res.error_seen         = err;
  endtask

  always @(posedge clk) begin
    seq_pins_t want, got;
    if (!rst_n) begin
      // block reset: registers to defaults, retry budget loaded from them
      hb_ticks  = HEARTBEAT_RST;
      retry_lim = RETRY_LIMIT_RST;
      boot_wait = BOOT_WAIT_RST;
      slp_pulse = SLEEP_PULSE_RST;
      wake_pulse = WAKE_PULSE_RST;
      rel_pulse = RELOAD_PULSE_RST;
      st        = ST_RST;
      dly       = 16'd0;
      hb        = hb_ticks;
      tries     = retry_lim;
      pin_rst   = 1'b1;
      pin_slp   = 1'b1;
      pin_rel   = 1'b1;
      expected_pins_q.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (expected_pins_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count++;
        end else begin
          want = expected_pins_q.pop_front();
          got  = seq_pins_t'(out_tdata[8:0]);
          check_field("reset_line", {3'b000, want.reset_line},
                      {3'b000, got.reset_line});
          check_field("sleep_request_line", {3'b000, want.sleep_request_line},
                      {3'b000, got.sleep_request_line});
          check_field("reload_line", {3'b000, want.reload_line},
                      {3'b000, got.reload_line});
          check_field("state_code", want.state_code, got.state_code);
          check_field("link_ready", {3'b000, want.link_ready},
                      {3'b000, got.link_ready});
          check_field("error_seen", {3'b000, want.error_seen},
                      {3'b000, got.error_seen});
        end
      end

      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEARTBEAT:    hb_ticks   = cfg_data;
          REG_RETRY_LIMIT:  retry_lim  = cfg_data[3:0];
          REG_BOOT_WAIT:    boot_wait  = cfg_data;
          REG_SLEEP_PULSE:  slp_pulse  = cfg_data;
          REG_WAKE_PULSE:   wake_pulse = cfg_data;
          REG_RELOAD_PULSE: rel_pulse  = cfg_data;
          default: ;
        endcase
      end

      // input beat: predict its result
      if (in_tvalid && in_tready) begin
        step_sequencer(in_tuser, in_tdata[0], in_tdata[1], want);
        expected_pins_q.push_back(want);
      end
    end
    pending_results = expected_pins_q.size();
  end

endmodule

// ===== verif/wifi_module_power_sequencer_tb.sv =====
// Testbench top for the radio module power sequencer: clock, reset, beat
// stimulus under several register settings, and the verdict.
// Depends on wmps_pkg, wifi_module_power_sequencer and wmps_checker.
`timescale 1ns / 1ps

module wifi_module_power_sequencer_tb;
  import wmps_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [2:0]  in_tuser   = 3'd0;   // cmd[2:0]
  logic [7:0]  in_tdata   = 8'd0;   // ready_n[0], sleep_status[1], pad [7:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // reset[0], sleep req[1], reload[2],
                                    // state[6:3], link[7], err[8], pad
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data   = 16'd0;

  logic        steady     = 1'b0;   // no idling on either side while set
  int unsigned fail_count;
  int unsigned pending_results;

  always #5 clk = ~clk;

  wifi_module_power_sequencer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wmps_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tuser        (in_tuser),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Result side: stalls about a quarter of the time
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // One input beat, with random idle cycles ahead of it
  task send_beat(input logic [2:0] cmd, input logic rdy_n, input logic slp_on);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, slp_on, rdy_n};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait for every predicted result to come back
  task wait_quiet;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task write_timing(input logic [15:0] hb, input logic [15:0] retries,
                    input logic [15:0] boot, input logic [15:0] slp,
                    input logic [15:0] wake, input logic [15:0] rel);
    write_reg(REG_HEARTBEAT, hb);
    write_reg(REG_RETRY_LIMIT, retries);
    write_reg(REG_BOOT_WAIT, boot);
    write_reg(REG_SLEEP_PULSE, slp);
    write_reg(REG_WAKE_PULSE, wake);
    write_reg(REG_RELOAD_PULSE, rel);
  endtask

  // Random walk of ticks, received bytes and requests; the line levels follow
  // a bias that changes every few dozen beats so that waits both succeed and
  // time out
  task run_random(input int count, input int calm_beats, input int pause_at);
    logic [2:0] cmd;
    int r, rdy_bias, slp_bias;
    rdy_bias = 50;
    slp_bias = 50;
    for (int i = 0; i < count; i++) begin
      if (i == 0 && calm_beats > 0) steady <= 1'b1;
      if (i == calm_beats) steady <= 1'b0;
      if (i == pause_at) wait_quiet();
      if (i % 40 == 0) begin
        r = $urandom_range(0, 2);
        rdy_bias = (r == 0) ? 15 : (r == 1) ? 50 : 90;
        r = $urandom_range(0, 2);
        slp_bias = (r == 0) ? 15 : (r == 1) ? 50 : 90;
      end
      r = $urandom_range(0, 99);
      if (r < 60)      cmd = CMD_TICK;
      else if (r < 68) cmd = CMD_RXBYTE;
      else if (r < 76) cmd = CMD_SLEEP;
      else if (r < 84) cmd = CMD_WAKE;
      else if (r < 91) cmd = CMD_RELOAD;
      else if (r < 95) cmd = 3'($urandom_range(5, 7));
      else             cmd = CMD_TICK;
      send_beat(cmd, $urandom_range(0, 99) < rdy_bias,
                $urandom_range(0, 99) < slp_bias);
    end
    steady <= 1'b0;
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through the states with the reset register values
    send_beat(3'd5, 1'b0, 1'b0);         // unused codes change nothing
    send_beat(3'd6, 1'b1, 1'b0);
    send_beat(3'd7, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b1, 1'b1);     // reset pin goes low
    send_beat(CMD_TICK, 1'b1, 1'b1);     // hold over, waiting for ready
    send_beat(CMD_TICK, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b1);     // module ready
    send_beat(CMD_RXBYTE, 1'b1, 1'b0);
    send_beat(CMD_SLEEP, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b0);     // already asleep
    send_beat(CMD_SLEEP, 1'b0, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b1);     // sleep pulse starts
    send_beat(CMD_TICK, 1'b1, 1'b1);
    send_beat(CMD_WAKE, 1'b1, 1'b1);
    send_beat(CMD_TICK, 1'b1, 1'b1);     // already awake: straight to ready
    send_beat(CMD_WAKE, 1'b0, 1'b0);
    send_beat(CMD_TICK, 1'b0, 1'b0);     // wake pulse starts
    send_beat(CMD_RELOAD, 1'b0, 1'b0);
    send_beat(CMD_TICK, 1'b1, 1'b0);     // reload pin goes low
    send_beat(CMD_SLEEP, 1'b1, 1'b1);    // request lands mid reload pulse
    send_beat(CMD_TICK, 1'b1, 1'b0);
    send_beat(CMD_RELOAD, 1'b0, 1'b1);
    send_beat(CMD_TICK, 1'b0, 1'b1);
    wait_quiet();

    // Short waits: every sequence completes, retries and errors happen
    write_timing(16'd4, 16'd0, 16'd2, 16'd2, 16'd1, 16'd2);
    run_random(300, 150, 220);
    wait_quiet();

    // Zero-length waits end on the next tick
    write_timing(16'd0, 16'd15, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(200, 0, -1);
    wait_quiet();

    // Largest values
    write_timing(16'hFFFF, 16'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(100, 0, -1);
    wait_quiet();

    // Mixed small settings
    repeat (5) begin
      write_timing(16'($urandom_range(0, 8)), 16'($urandom_range(0, 15)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 5)),
                   16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)));
      run_random(150, 0, -1);
      wait_quiet();
    end

    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
